[src/ledbpw_pkg.sv]
// ----------------------------------------------------------------------------
// ledbpw_pkg: LED bit-plane writer package
// Codes, register map and state type shared by the bit-plane writer.
// ----------------------------------------------------------------------------
package ledbpw_pkg;

  localparam int ADDR_W = 4;

  localparam logic [1:0] KIND_RGB  = 2'd0;
  localparam logic [1:0] KIND_RGBW = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] REG_RTZ    = 2'd0;
  localparam logic [1:0] REG_KIND   = 2'd1;
  localparam logic [1:0] REG_ORDER  = 2'd2;
  localparam logic [1:0] REG_BRIGHT = 2'd3;

  localparam logic [1:0] LED_OTHER   = 2'd0;
  localparam logic [1:0] LED_CLOCKED = 2'd1;
  localparam logic [1:0] LED_BRIGHT  = 2'd2;
  localparam logic [1:0] LED_FLAG    = 2'd3;

  localparam logic [2:0] ORD_RGB = 3'd0;
  localparam logic [2:0] ORD_RBG = 3'd1;
  localparam logic [2:0] ORD_GRB = 3'd2;
  localparam logic [2:0] ORD_GBR = 3'd3;
  localparam logic [2:0] ORD_BRG = 3'd4;
  localparam logic [2:0] ORD_BGR = 3'd5;

  localparam logic [7:0] FLAG_BASE = 8'hC0;
  localparam logic [5:0] LEN3 = 6'd24;
  localparam logic [5:0] LEN4 = 6'd32;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RMW   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

[src/led_pixel_bitplane_writer_core.sv]
// ----------------------------------------------------------------------------
// led_pixel_bitplane_writer_core: bit-sliced pixel buffer for eight strips
// Byte i of the buffer holds bit i of the serial stream of every port, port p
// at bit p. Pixel writes read-modify-write one port lane, byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transfer:
//   three-colour write, four-colour write or buffer byte read. Each request
//   gives exactly one result transfer on out_valid/out_ready (read_data,
//   range_error). The user must write registers over the APB port only
//   while idle; the block itself does not enforce it. Sequence: a write
//   walks its 24 or 32 buffer bytes through the single byte-wide buffer
//   RAM, one byte per cycle with the write-back of byte k-1 overlapping
//   the read of byte k. The result is presented from the done step, and
//   in_ready returns with it. A read passes through the read step to the
//   done step; a dropped request goes straight to the done step.
//   Reset: control clears, registers take their defaults and the buffer
//   is zeroed over all STORE_BYTES addresses; in_ready stays low meanwhile.
//   A stalled result waits in the output register; the next request is
//   taken and processed, and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module led_pixel_bitplane_writer_core #(
  parameter int STORE_BYTES = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [2:0]                    port,
  input  logic [7:0]                    pixel_index,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic [7:0]                    white,
  input  logic [12:0]                   read_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    read_data,
  output logic                          range_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ledbpw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ledbpw_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [16:0] STORE_LIMIT = 17'(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  // configuration
  logic       rtz_mode;
  logic [1:0] led_kind;
  logic [2:0] colour_order;
  logic [7:0] global_brightness;

  // buffer RAM
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    mem_rdata;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;

  // sequencer
  state_t        state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [5:0]    cnt;
  logic [5:0]    slot_len;
  logic [31:0]   pattern;
  logic [2:0]    lane;
  logic          res_err;
  logic          res_read;

  // request decode
  logic [16:0] acc_base;
  logic [5:0]  acc_len;
  logic [31:0] acc_pattern;
  logic        acc_err;
  logic        acc_read;
  logic [7:0]  v0, v1, v2;
  logic [7:0]  flag_byte;
  logic [16:0] pix3;
  logic [16:0] pix4;
  logic [16:0] pix4n;
  logic [7:0]  lane_mask;
  logic [7:0]  merged;
  logic        out_free;

  assign pready   = 1'b1;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (paddr[3:2])
      REG_RTZ:    prdata = {31'd0, rtz_mode};
      REG_KIND:   prdata = {30'd0, led_kind};
      REG_ORDER:  prdata = {29'd0, colour_order};
      REG_BRIGHT: prdata = {24'd0, global_brightness};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rtz_mode          <= 1'b1;
      led_kind          <= LED_OTHER;
      colour_order      <= ORD_GRB;
      global_brightness <= 8'hFF;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_RTZ:    rtz_mode          <= pwdata[0];
        REG_KIND:   led_kind          <= pwdata[1:0];
        REG_ORDER:  colour_order      <= pwdata[2:0];
        REG_BRIGHT: global_brightness <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (colour_order)
      ORD_RGB: begin v0 = red;   v1 = green; v2 = blue;  end
      ORD_RBG: begin v0 = red;   v1 = blue;  v2 = green; end
      ORD_GBR: begin v0 = green; v1 = blue;  v2 = red;   end
      ORD_BRG: begin v0 = blue;  v1 = red;   v2 = green; end
      ORD_BGR: begin v0 = blue;  v1 = green; v2 = red;   end
      default: begin v0 = green; v1 = red;   v2 = blue;  end
    endcase
  end

  assign flag_byte = FLAG_BASE | {2'b00, ~blue[7:6], ~green[7:6], ~red[7:6]};
  assign pix3  = ({9'd0, pixel_index} << 4) + ({9'd0, pixel_index} << 3);
  assign pix4  = {9'd0, pixel_index} << 5;
  assign pix4n = pix4 + 17'd32;

  always_comb begin
    acc_base    = 17'd0;
    acc_len     = LEN4;
    acc_pattern = 32'd0;
    acc_err     = 1'b0;
    acc_read    = 1'b0;
    case (kind)
      KIND_RGB: begin
        if (rtz_mode || led_kind == LED_CLOCKED) begin
          acc_base    = pix3;
          acc_len     = LEN3;
          acc_pattern = {v0, v1, v2, 8'h00};
        end else if (led_kind == LED_BRIGHT) begin
          acc_base    = pix4n;
          acc_pattern = {global_brightness, blue, green, red};
        end else if (led_kind == LED_FLAG) begin
          acc_base    = pix4n;
          acc_pattern = {flag_byte, red, green, blue};
        end else begin
          acc_err = 1'b1;
        end
        if (acc_base + {11'd0, acc_len} > STORE_LIMIT) begin
          acc_err = 1'b1;
        end
      end
      KIND_RGBW: begin
        acc_base    = pix4;
        acc_pattern = {green, red, blue, white};
        if (acc_base + {11'd0, acc_len} > STORE_LIMIT) begin
          acc_err = 1'b1;
        end
      end
      KIND_READ: begin
        acc_read = 1'b1;
        acc_base = {4'd0, read_address};
        if ({4'd0, read_address} >= STORE_LIMIT) begin
          acc_err = 1'b1;
        end
      end
      default: acc_err = 1'b1;
    endcase
  end

  assign lane_mask = 8'd1 << lane;
  assign merged    = (mem_rdata & ~lane_mask) | ({7'd0, pattern[31]} << lane);

  always_comb begin
    mem_we    = (state == ST_CLEAR) || (state == ST_RMW && cnt != 6'd0);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : wr_ptr;
    mem_wdata = (state == ST_CLEAR) ? 8'd0 : merged;
    mem_re    = (state == ST_RMW && cnt < slot_len) || (state == ST_READ);
    mem_raddr = rd_ptr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            rd_ptr   <= AW'(acc_base);
            slot_len <= acc_len;
            pattern  <= acc_pattern;
            lane     <= port;
            cnt      <= 6'd0;
            res_err  <= acc_err;
            res_read <= acc_read && !acc_err;
            if (acc_err) begin
              state <= ST_DONE;
            end else if (acc_read) begin
              state <= ST_READ;
            end else begin
              state <= ST_RMW;
            end
          end
        end
        ST_RMW: begin
          if (cnt < slot_len) begin
            rd_ptr <= rd_ptr + 1'b1;
            wr_ptr <= rd_ptr;
          end
          if (cnt != 6'd0) begin
            pattern <= pattern << 1;
          end
          cnt <= cnt + 6'd1;
          if (cnt == slot_len) begin
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            read_data   <= res_read ? mem_rdata : 8'd0;
            range_error <= res_err;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rmw_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("write-back and read hit the same buffer byte");

  a_rmw_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW) |-> (cnt <= slot_len))
    else $error("byte counter ran past the slot length");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result loaded outside the done step");

  a_error_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (read_data == 8'd0))
    else $error("dropped request returned data");

endmodule

[tb/led_pixel_bitplane_writer_core_test.sv]
// ----------------------------------------------------------------------------
// led_pixel_bitplane_writer_core_test: self-checking bench for the writer core
// Mirrors the bit-plane buffer and the four registers, predicts read_data and
// range_error for every request transfer and checks each result in order.
// Directed corner cases come first, then random traffic over several register
// settings with the sender and receiver idling in turn.
// ----------------------------------------------------------------------------
module led_pixel_bitplane_writer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ledbpw_pkg::*;

  localparam int STORE_BYTES = 8192;
  localparam int PHASE_ITEMS = 210;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  port;
    logic [7:0]  pixel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
    logic [12:0] addr;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        kind = '0;
  logic [2:0]        port = '0;
  logic [7:0]        pixel_index = '0;
  logic [7:0]        red = '0;
  logic [7:0]        green = '0;
  logic [7:0]        blue = '0;
  logic [7:0]        white = '0;
  logic [12:0]       read_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        read_data;
  logic              range_error;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // mirror of the buffer and registers
  logic [7:0] plane_mirror [STORE_BYTES];
  logic       cfg_rtz = 1'b1;
  logic [1:0] cfg_led_kind = LED_OTHER;
  logic [2:0] cfg_order = ORD_GRB;
  logic [7:0] cfg_bright = 8'hFF;

  reply_t pending_replies [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int n_requests = 0;
  int n_reads = 0;
  int n_dropped = 0;
  int n_settings = 0;
  int n_results = 0;
  int hot_base = 0;

  led_pixel_bitplane_writer_core #(
    .STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .port(port),
    .pixel_index(pixel_index),
    .red(red),
    .green(green),
    .blue(blue),
    .white(white),
    .read_address(read_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .range_error(range_error),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Writes n MSB-first slots into one port lane; returns 1 when dropped.
  function automatic logic store_lane_slots(input logic [2:0] lane, input int pix,
                                            input int n, input logic [3:0][7:0] slots);
    int base;
    base = pix * n * 8;
    if (base + n * 8 > STORE_BYTES) begin
      return 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      for (int b = 0; b < 8; b++) begin
        plane_mirror[base + i * 8 + b][lane] = slots[i][7 - b];
      end
    end
    return 1'b0;
  endfunction

  function automatic reply_t bitplane_reply(input pixel_req_t rq);
    reply_t           rep;
    logic [3:0][7:0]  slots;
    logic [7:0]       nr;
    logic [7:0]       ng;
    logic [7:0]       nb;
    rep = '0;
    slots = '0;
    nr = ~rq.red;
    ng = ~rq.green;
    nb = ~rq.blue;
    case (rq.kind)
      KIND_RGB: begin
        if (cfg_rtz || cfg_led_kind == LED_CLOCKED) begin
          case (cfg_order)
            ORD_RGB: begin slots[0] = rq.red;   slots[1] = rq.green; slots[2] = rq.blue;  end
            ORD_RBG: begin slots[0] = rq.red;   slots[1] = rq.blue;  slots[2] = rq.green; end
            ORD_GBR: begin slots[0] = rq.green; slots[1] = rq.blue;  slots[2] = rq.red;   end
            ORD_BRG: begin slots[0] = rq.blue;  slots[1] = rq.red;   slots[2] = rq.green; end
            ORD_BGR: begin slots[0] = rq.blue;  slots[1] = rq.green; slots[2] = rq.red;   end
            default: begin slots[0] = rq.green; slots[1] = rq.red;   slots[2] = rq.blue;  end
          endcase
          rep.err = store_lane_slots(rq.port, int'(rq.pixel), 3, slots);
        end else if (cfg_led_kind == LED_BRIGHT) begin
          slots[0] = cfg_bright;
          slots[1] = rq.blue;
          slots[2] = rq.green;
          slots[3] = rq.red;
          rep.err = store_lane_slots(rq.port, int'(rq.pixel) + 1, 4, slots);
        end else if (cfg_led_kind == LED_FLAG) begin
          slots[0] = FLAG_BASE | ((nb & 8'hC0) >> 2) | ((ng & 8'hC0) >> 4)
                   | ((nr & 8'hC0) >> 6);
          slots[1] = rq.red;
          slots[2] = rq.green;
          slots[3] = rq.blue;
          rep.err = store_lane_slots(rq.port, int'(rq.pixel) + 1, 4, slots);
        end else begin
          rep.err = 1'b1;
        end
      end
      KIND_RGBW: begin
        slots[0] = rq.green;
        slots[1] = rq.red;
        slots[2] = rq.blue;
        slots[3] = rq.white;
        rep.err = store_lane_slots(rq.port, int'(rq.pixel), 4, slots);
      end
      KIND_READ: begin
        if (int'(rq.addr) < STORE_BYTES) begin
          rep.data = plane_mirror[rq.addr];
        end else begin
          rep.err = 1'b1;
        end
      end
      default: rep.err = 1'b1;
    endcase
    return rep;
  endfunction

  task automatic send_request(input pixel_req_t rq);
    reply_t rep;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= rq.kind;
    port <= rq.port;
    pixel_index <= rq.pixel;
    red <= rq.red;
    green <= rq.green;
    blue <= rq.blue;
    white <= rq.white;
    read_address <= rq.addr;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    rep = bitplane_reply(rq);
    pending_replies.push_back(rep);
    n_requests++;
    if (rq.kind == KIND_READ) begin
      n_reads++;
    end
    if (rep.err) begin
      n_dropped++;
    end
  endtask

  task automatic send_fields(input logic [1:0] k, input logic [2:0] p, input logic [7:0] pix,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] w, input logic [12:0] a);
    pixel_req_t rq;
    rq = '{kind: k, port: p, pixel: pix, red: r, green: g, blue: b, white: w, addr: a};
    send_request(rq);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RTZ:    cfg_rtz = value[0];
      REG_KIND:   cfg_led_kind = value[1:0];
      REG_ORDER:  cfg_order = value[2:0];
      REG_BRIGHT: cfg_bright = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic rtz, input logic [1:0] lk, input logic [2:0] ord,
                            input logic [7:0] bright);
    wait_idle();
    write_register(REG_RTZ, 32'(rtz));
    write_register(REG_KIND, 32'(lk));
    write_register(REG_ORDER, 32'(ord));
    write_register(REG_BRIGHT, 32'(bright));
    n_settings++;
  endtask

  function automatic pixel_req_t random_request();
    pixel_req_t rq;
    int         sel;
    int         pick;
    sel = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    rq.port = 3'($urandom_range(0, 7));
    rq.red = 8'($urandom);
    rq.green = 8'($urandom);
    rq.blue = 8'($urandom);
    rq.white = 8'($urandom);
    rq.addr = 13'($urandom);
    if (pick < 60) begin
      rq.pixel = 8'($urandom_range(0, 15));
    end else if (pick < 95) begin
      rq.pixel = 8'($urandom);
    end else begin
      rq.pixel = 8'hFF;
    end
    if (sel < 45) begin
      rq.kind = KIND_RGB;
      if (cfg_rtz || cfg_led_kind == LED_CLOCKED) begin
        hot_base = int'(rq.pixel) * 24;
      end else begin
        hot_base = (int'(rq.pixel) + 1) * 32;
      end
    end else if (sel < 65) begin
      rq.kind = KIND_RGBW;
      hot_base = int'(rq.pixel) * 32;
    end else if (sel < 95) begin
      rq.kind = KIND_READ;
      if ($urandom_range(0, 99) < 60) begin
        rq.addr = 13'(hot_base + $urandom_range(0, 31));
      end
    end else begin
      rq.kind = KIND_BAD;
    end
    return rq;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_replies.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_replies.pop_front();
        if (read_data !== want.data) begin
          report_mismatch($sformatf("read_data %0h, expected %0h", read_data, want.data));
        end
        if (range_error !== want.err) begin
          report_mismatch($sformatf("range_error %0b, expected %0b", range_error, want.err));
        end
      end
    end
  end

  task automatic test_default_settings();
    send_fields(KIND_RGB, 3'd0, 8'd0, 8'hFF, 8'h00, 8'hA5, 8'h00, 13'd0);
    send_fields(KIND_RGB, 3'd7, 8'd255, 8'h00, 8'hFF, 8'h5A, 8'hFF, 13'h1FFF);
    send_fields(KIND_READ, 3'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 13'd0);
    send_fields(KIND_READ, 3'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 13'd8);
    send_fields(KIND_READ, 3'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 13'd6120);
    send_fields(KIND_RGBW, 3'd7, 8'd255, 8'h00, 8'hFF, 8'hFF, 8'h81, 13'd0);
    send_fields(KIND_READ, 3'd7, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 13'h1FFF);
    send_fields(KIND_READ, 3'd7, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 13'd8160);
    send_fields(KIND_BAD, 3'd2, 8'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 13'd0);
  endtask

  task automatic test_framed_paths();
    // no three-colour path selected
    set_config(1'b0, LED_OTHER, ORD_GRB, 8'hFF);
    send_fields(KIND_RGB, 3'd4, 8'd1, 8'h12, 8'h34, 8'h56, 8'h00, 13'd0);
    send_fields(KIND_RGBW, 3'd4, 8'd1, 8'h12, 8'h34, 8'h56, 8'h78, 13'd0);
    set_config(1'b0, LED_BRIGHT, ORD_RGB, 8'h00);
    send_fields(KIND_RGB, 3'd3, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'h00, 13'd0);
    send_fields(KIND_RGB, 3'd3, 8'd0, 8'hC3, 8'h3C, 8'h81, 8'h00, 13'd0);
    send_fields(KIND_READ, 3'd3, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 13'd40);
    set_config(1'b0, LED_FLAG, ORD_BGR, 8'h80);
    send_fields(KIND_RGB, 3'd5, 8'd1, 8'h00, 8'hFF, 8'h3C, 8'h00, 13'd0);
    send_fields(KIND_READ, 3'd5, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 13'd65);
    send_fields(KIND_RGB, 3'd5, 8'd255, 8'h80, 8'h40, 8'hC0, 8'h00, 13'd0);
    // undefined colour orders fall back to GRB
    set_config(1'b0, LED_CLOCKED, 3'd7, 8'hFF);
    send_fields(KIND_RGB, 3'd1, 8'd2, 8'hF0, 8'h0F, 8'hAA, 8'h00, 13'd0);
    send_fields(KIND_READ, 3'd1, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 13'd56);
    set_config(1'b1, LED_FLAG, 3'd6, 8'h01);
    send_fields(KIND_RGB, 3'd6, 8'd3, 8'h01, 8'h02, 8'h04, 8'h00, 13'd0);
  endtask

  task automatic test_random_traffic();
    logic [1:0] kinds [8];
    logic       rtzs [8];
    logic [7:0] bright;
    kinds = '{LED_OTHER, LED_CLOCKED, LED_BRIGHT, LED_FLAG,
              LED_OTHER, LED_BRIGHT, LED_FLAG, LED_BRIGHT};
    rtzs = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int ph = 0; ph < 8; ph++) begin
      bright = (ph == 2) ? 8'h00 : (ph == 7) ? 8'hFF : 8'($urandom);
      set_config(rtzs[ph], kinds[ph], 3'(ph), bright);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_request(random_request());
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    foreach (plane_mirror[i]) begin
      plane_mirror[i] = 8'h00;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_default_settings();
    test_framed_paths();
    test_random_traffic();
    wait_idle();
    repeat (40) @(posedge clk);
    if (pending_replies.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_replies.size()));
    end
    $display("covered %0d requests (%0d reads, %0d dropped), %0d results checked",
             n_requests, n_reads, n_dropped, n_results);
    $display("over %0d register settings, %0d mismatches", n_settings, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
